@@ src/jsu_pkg.sv @@
// Package: shared types, constants and decode helpers for the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AccumW  = 12;

  localparam logic [ByteW-1:0] ChQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash     = 8'h2F;
  localparam logic [ByteW-1:0] ChLowerN    = 8'h6E;
  localparam logic [ByteW-1:0] ChLowerR    = 8'h72;
  localparam logic [ByteW-1:0] ChLowerT    = 8'h74;
  localparam logic [ByteW-1:0] ChLowerB    = 8'h62;
  localparam logic [ByteW-1:0] ChLowerF    = 8'h66;
  localparam logic [ByteW-1:0] ChLowerU    = 8'h75;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef struct packed {
    logic             ok;
    logic [ByteW-1:0] value;
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic esc_t esc_decode(input logic [ByteW-1:0] b);
    esc_t r;
    r.ok    = 1'b1;
    r.value = b;
    case (b)
      ChQuote, ChBackslash, ChSlash: r.value = b;
      ChLowerN: r.value = 8'h0A;
      ChLowerR: r.value = 8'h0D;
      ChLowerT: r.value = 8'h09;
      ChLowerB: r.value = 8'h08;
      ChLowerF: r.value = 8'h0C;
      default: begin
        r.ok    = 1'b0;
        r.value = '0;
      end
    endcase
    return r;
  endfunction

  function automatic hex_t hex_decode(input logic [ByteW-1:0] b);
    hex_t r;
    r.ok    = 1'b1;
    r.value = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r.value = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.value = b[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ src/jsu_if.sv @@
// Interfaces: input byte channel and decoded result channel with valid/ready handshake.
interface jsu_in_if import jsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             at_end;

  modport source (output valid, output data_byte, output at_end, input ready);
  modport sink (input valid, input data_byte, input at_end, output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CountW-1:0]  byte_count;
  logic [ByteW-1:0]   out_byte_0;
  logic [ByteW-1:0]   out_byte_1;
  logic [ByteW-1:0]   out_byte_2;
  logic [StatusW-1:0] status;

  modport source (output valid, output byte_count, output out_byte_0, output out_byte_1,
                  output out_byte_2, output status, input ready);
  modport sink (input valid, input byte_count, input out_byte_0, input out_byte_1,
                input out_byte_2, input status, output ready);
endinterface

@@ src/json_string_unescape.sv @@
// Top level: streaming JSON string literal unescaper with UTF-8 output of \u escapes.
//
// in_i carries one raw text byte per item (data_byte), or an end-of-buffer mark
// (at_end). out_o returns exactly one result item per input item: up to three
// decoded bytes with their count, and a status of in progress, complete at the
// closing quote, or error. The first byte must be a double quote; after the
// closing quote or any error the block waits for a new opening quote.
//
// An accepted item is held in an input register; when the output stage advances,
// the decode logic and the string state update and the result is loaded into the
// output register, from which it is offered on out_o. Throughput is one item per
// cycle while out_o.ready stays high: the input register takes a new item while
// the output register is passed on, and the two stages advance together.
//
// Reset clears both stages and returns the decoder to waiting for an opening
// quote. When the receiver holds out_o.ready low, the output register holds
// its result, the input register fills once more, and then in_i.ready drops
// until the result is taken; no item is lost or repeated.
module json_string_unescape
  import jsu_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  jsu_in_if.sink   in_i,
  jsu_out_if.source out_o
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_end_q;

  phase_e            phase_q, phase_d;
  logic [1:0]        digits_q, digits_d;
  logic [AccumW-1:0] accum_q, accum_d;

  logic               out_valid_q;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0]   ob0_q, ob0_d;
  logic [ByteW-1:0]   ob1_q, ob1_d;
  logic [ByteW-1:0]   ob2_q, ob2_d;
  status_e            status_q, status_d;

  logic        advance;
  logic        take;
  esc_t        esc;
  hex_t        hex;
  logic [15:0] cp;

  assign advance    = !out_valid_q || out_o.ready;
  assign take       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  assign esc = esc_decode(in_byte_q);
  assign hex = hex_decode(in_byte_q);
  assign cp  = {accum_q, hex.value};

  always_comb begin
    phase_d  = phase_q;
    digits_d = digits_q;
    accum_d  = accum_q;
    cnt_d    = '0;
    ob0_d    = '0;
    ob1_d    = '0;
    ob2_d    = '0;
    status_d = ST_BUSY;
    if (in_end_q) begin
      status_d = ST_ERROR;
      phase_d  = PH_IDLE;
      digits_d = '0;
      accum_d  = '0;
    end else begin
      case (phase_q)
        PH_BODY: begin
          if (in_byte_q == ChQuote) begin
            status_d = ST_DONE;
            phase_d  = PH_IDLE;
          end else if (in_byte_q == ChBackslash) begin
            phase_d = PH_ESC;
          end else begin
            ob0_d = in_byte_q;
            cnt_d = 2'd1;
          end
        end
        PH_ESC: begin
          if (esc.ok) begin
            ob0_d   = esc.value;
            cnt_d   = 2'd1;
            phase_d = PH_BODY;
          end else if (in_byte_q == ChLowerU) begin
            phase_d  = PH_HEX;
            digits_d = '0;
            accum_d  = '0;
          end else begin
            status_d = ST_ERROR;
            phase_d  = PH_IDLE;
          end
        end
        PH_HEX: begin
          if (!hex.ok) begin
            status_d = ST_ERROR;
            phase_d  = PH_IDLE;
            digits_d = '0;
            accum_d  = '0;
          end else if (digits_q == 2'd3) begin
            if (cp[15:7] == '0) begin
              ob0_d = cp[7:0];
              cnt_d = 2'd1;
            end else if (cp[15:11] == '0) begin
              ob0_d = {3'b110, cp[10:6]};
              ob1_d = {2'b10, cp[5:0]};
              cnt_d = 2'd2;
            end else begin
              ob0_d = {4'b1110, cp[15:12]};
              ob1_d = {2'b10, cp[11:6]};
              ob2_d = {2'b10, cp[5:0]};
              cnt_d = 2'd3;
            end
            phase_d  = PH_BODY;
            digits_d = '0;
            accum_d  = '0;
          end else begin
            accum_d  = cp[AccumW-1:0];
            digits_d = digits_q + 2'd1;
          end
        end
        default: begin
          if (in_byte_q == ChQuote) begin
            phase_d = PH_BODY;
          end else begin
            status_d = ST_ERROR;
            phase_d  = PH_IDLE;
            digits_d = '0;
            accum_d  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      digits_q    <= '0;
      accum_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (take) begin
        phase_q  <= phase_d;
        digits_q <= digits_d;
        accum_q  <= accum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_end_q  <= in_i.at_end;
    end
    if (take) begin
      cnt_q    <= cnt_d;
      ob0_q    <= ob0_d;
      ob1_q    <= ob1_d;
      ob2_q    <= ob2_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.byte_count = cnt_q;
  assign out_o.out_byte_0 = ob0_q;
  assign out_o.out_byte_1 = ob1_q;
  assign out_o.out_byte_2 = ob2_q;
  assign out_o.status     = status_q;

endmodule

@@ tb/json_string_unescape_tb.sv @@
`timescale 1ns / 100ps
// Testbench: directed and random byte streams with an own decoder model checking every result.
module json_string_unescape_tb;
  import jsu_pkg::*;

  typedef struct packed {
    logic [CountW-1:0]  cnt;
    logic [ByteW-1:0]   b0;
    logic [ByteW-1:0]   b1;
    logic [ByteW-1:0]   b2;
    logic [StatusW-1:0] st;
  } decoded_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_bus ();
  jsu_out_if out_bus ();

  json_string_unescape u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  phase_e      dec_phase;
  logic [1:0]  dec_digits;
  logic [15:0] dec_code;
  decoded_t    pending_results[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned out_hold;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("json_string_unescape_tb NOT OK");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void reset_decoder();
    dec_phase  = PH_IDLE;
    dec_digits = 2'd0;
    dec_code   = 16'd0;
  endfunction

  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b1, b[3:0]};
    if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h61 + 8'd10)};
    if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [ByteW-1:0] esc_letter(input int unsigned idx);
    case (idx)
      0: return ChQuote;
      1: return ChBackslash;
      2: return ChSlash;
      3: return ChLowerN;
      4: return ChLowerR;
      5: return ChLowerT;
      6: return ChLowerB;
      default: return ChLowerF;
    endcase
  endfunction

  function automatic bit is_esc_letter(input logic [ByteW-1:0] b);
    case (b)
      ChQuote, ChBackslash, ChSlash, ChLowerN, ChLowerR, ChLowerT, ChLowerB, ChLowerF,
      ChLowerU: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic decoded_t decode_step(input logic [ByteW-1:0] b, input logic e);
    decoded_t    r;
    logic [4:0]  h;
    logic [15:0] cp;
    r    = '0;
    r.st = ST_BUSY;
    if (e) begin
      r.st = ST_ERROR;
      reset_decoder();
    end else begin
      case (dec_phase)
        PH_IDLE: begin
          if (b == ChQuote) begin
            dec_phase = PH_BODY;
          end else begin
            r.st = ST_ERROR;
            reset_decoder();
          end
        end
        PH_BODY: begin
          if (b == ChQuote) begin
            r.st = ST_DONE;
            reset_decoder();
          end else if (b == ChBackslash) begin
            dec_phase = PH_ESC;
          end else begin
            r.cnt = 2'd1;
            r.b0  = b;
          end
        end
        PH_ESC: begin
          dec_phase = PH_BODY;
          r.cnt     = 2'd1;
          case (b)
            ChQuote, ChBackslash, ChSlash: r.b0 = b;
            ChLowerN: r.b0 = 8'h0A;
            ChLowerR: r.b0 = 8'h0D;
            ChLowerT: r.b0 = 8'h09;
            ChLowerB: r.b0 = 8'h08;
            ChLowerF: r.b0 = 8'h0C;
            ChLowerU: begin
              r.cnt      = 2'd0;
              dec_phase  = PH_HEX;
              dec_digits = 2'd0;
              dec_code   = 16'd0;
            end
            default: begin
              r.cnt = 2'd0;
              r.st  = ST_ERROR;
              reset_decoder();
            end
          endcase
        end
        default: begin
          h = hex_digit(b);
          if (!h[4]) begin
            r.st = ST_ERROR;
            reset_decoder();
          end else begin
            cp = {dec_code[11:0], h[3:0]};
            if (dec_digits == 2'd3) begin
              if (cp < 16'h0080) begin
                r.cnt = 2'd1;
                r.b0  = cp[7:0];
              end else if (cp < 16'h0800) begin
                r.cnt = 2'd2;
                r.b0  = 8'hC0 | {3'b000, cp[10:6]};
                r.b1  = 8'h80 | {2'b00, cp[5:0]};
              end else begin
                r.cnt = 2'd3;
                r.b0  = 8'hE0 | {4'b0000, cp[15:12]};
                r.b1  = 8'h80 | {2'b00, cp[11:6]};
                r.b2  = 8'h80 | {2'b00, cp[5:0]};
              end
              dec_phase  = PH_BODY;
              dec_digits = 2'd0;
              dec_code   = 16'd0;
            end else begin
              dec_code   = cp;
              dec_digits = dec_digits + 2'd1;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_item(input logic [ByteW-1:0] b, input logic e);
    int unsigned gap;
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.at_end    <= e;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(decode_step(b, e));
    items_sent++;
    @(negedge clk);
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_unicode(input logic [15:0] cp);
    send_item(ChBackslash, 1'b0);
    send_item(ChLowerU, 1'b0);
    for (int i = 3; i >= 0; i--) begin
      send_item(hex_char(cp[i*4 +: 4], $urandom_range(0, 1)), 1'b0);
    end
  endtask

  task automatic send_bad_hex();
    logic [ByteW-1:0] b;
    int unsigned      k;
    k = $urandom_range(0, 3);
    send_item(ChBackslash, 1'b0);
    send_item(ChLowerU, 1'b0);
    repeat (k) send_item(hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1)), 1'b0);
    do b = 8'($urandom_range(0, 255)); while (hex_digit(b) != 5'd0);
    send_item(b, 1'b0);
  endtask

  task automatic send_unknown_escape();
    logic [ByteW-1:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_esc_letter(b));
    send_item(ChBackslash, 1'b0);
    send_item(b, 1'b0);
  endtask

  task automatic test_missing_quote();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_plain_bytes();
    send_item(ChQuote, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h1F, 1'b0);
    send_item(ChQuote, 1'b0);
  endtask

  task automatic test_simple_escapes();
    send_item(ChQuote, 1'b0);
    for (int unsigned i = 0; i < 8; i++) begin
      send_item(ChBackslash, 1'b0);
      send_item(esc_letter(i), 1'b0);
    end
    send_item(ChQuote, 1'b0);
  endtask

  task automatic test_unicode_max();
    send_item(ChQuote, 1'b0);
    send_item(ChBackslash, 1'b0);
    send_item(ChLowerU, 1'b0);
    send_item(hex_char(4'hF, 1'b1), 1'b0);
    send_item(hex_char(4'hF, 1'b0), 1'b0);
    send_item(hex_char(4'hF, 1'b1), 1'b0);
    send_item(hex_char(4'hF, 1'b0), 1'b0);
    send_item(ChQuote, 1'b0);
  endtask

  task automatic test_decode_errors();
    send_item(ChQuote, 1'b0);
    send_item(ChBackslash, 1'b0);
    send_item(ChLowerU, 1'b0);
    send_item(8'h67, 1'b0);
    send_item(ChQuote, 1'b0);
    send_item(ChBackslash, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(ChQuote, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_streams(input int unsigned count);
    int unsigned target;
    int unsigned kind;
    int unsigned pieces;
    int unsigned p;
    logic [15:0] cp;
    logic [ByteW-1:0] b;
    target = items_sent + count;
    while (items_sent < target) begin
      no_idle = ($urandom_range(0, 7) == 0);
      kind    = $urandom_range(0, 99);
      if (kind < 78) begin
        send_item(ChQuote, 1'b0);
        pieces = $urandom_range(0, 10);
        repeat (pieces) begin
          p = $urandom_range(0, 9);
          if (p < 4) begin
            do b = 8'($urandom_range(0, 255)); while (b == ChQuote || b == ChBackslash);
            send_item(b, 1'b0);
          end else if (p < 6) begin
            send_item(ChBackslash, 1'b0);
            send_item(esc_letter($urandom_range(0, 7)), 1'b0);
          end else if (p < 9) begin
            case ($urandom_range(0, 7))
              0: cp = 16'($urandom_range(16'h0000, 16'h007F));
              1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
              2: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
              3: begin
                case ($urandom_range(0, 5))
                  0: cp = 16'h0000;
                  1: cp = 16'h007F;
                  2: cp = 16'h0080;
                  3: cp = 16'h07FF;
                  4: cp = 16'h0800;
                  default: cp = 16'hFFFF;
                endcase
              end
              default: cp = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_unicode(cp);
          end else begin
            send_item(8'($urandom_range(0, 31)), 1'b0);
          end
        end
        case ($urandom_range(0, 9))
          8: send_item(8'($urandom_range(0, 255)), 1'b1);
          9: begin
            if ($urandom_range(0, 1)) send_bad_hex();
            else send_unknown_escape();
          end
          default: send_item(ChQuote, 1'b0);
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    out_bus.ready = 1'b0;
    out_hold      = 0;
    forever begin
      @(negedge clk);
      if (out_hold != 0) begin
        out_bus.ready <= 1'b0;
        out_hold--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 25) out_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: cnt=%0d bytes=%h %h %h status=%0d", out_bus.byte_count,
                   out_bus.out_byte_0, out_bus.out_byte_1, out_bus.out_byte_2, out_bus.status);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_bus.byte_count !== want.cnt || out_bus.out_byte_0 !== want.b0 ||
            out_bus.out_byte_1 !== want.b1 || out_bus.out_byte_2 !== want.b2 ||
            out_bus.status !== want.st) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp cnt=%0d bytes=%h %h %h status=%0d, got cnt=%0d bytes=%h %h %h status=%0d",
                     want.cnt, want.b0, want.b1, want.b2, want.st, out_bus.byte_count,
                     out_bus.out_byte_0, out_bus.out_byte_1, out_bus.out_byte_2, out_bus.status);
          end
        end
      end
    end
  end

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.at_end    = 1'b0;
    rst_n            = 1'b0;
    mismatches       = 0;
    items_sent       = 0;
    no_idle          = 1'b0;
    reset_decoder();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_missing_quote();
    test_plain_bytes();
    test_simple_escapes();
    test_unicode_max();
    test_decode_errors();
    test_random_streams(600);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("json_string_unescape_tb OK");
    end else begin
      $display("json_string_unescape_tb NOT OK");
    end
    $finish;
  end

endmodule
